/* rtl/dbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dbs_pkg;

  localparam int MAX_PIXELS = 524288;
  localparam int MAX_FRAMES = 256;

  localparam int DEPTH_W = 16;
  localparam int FP_W    = 20;
  localparam int MARGIN_W = 16;
  localparam int PIX_AW  = $clog2(MAX_PIXELS);
  localparam int SZ_W    = (FP_W > PIX_AW + 1) ? FP_W : PIX_AW + 1;
  localparam int FRM_W   = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W   = $clog2(MAX_FRAMES * 65535 + 1);
  localparam int PROD_W  = DEPTH_W + FRM_W;
  localparam int CMP_W   = PROD_W + 1;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 3);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = CFG_IDX_W'(1);

  localparam logic [FP_W-1:0]     FP_RESET     = FP_W'(307200);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = '0;

  localparam logic REQ_LEARN    = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [DEPTH_W-1:0] depth;
  } in_word_t;

  typedef struct packed {
    logic foreground;
    logic last_of_frame;
  } out_word_t;

  typedef enum logic {
    PH_CLEAR,
    PH_RUN
  } phase_t;

endpackage

`default_nettype wire

/* rtl/depth_background_subtractor_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_word_t  {req_type, depth}
// out_      output     out_valid/out_stall out_word_t {foreground, last_of_frame}
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word per cycle sustained while in_stall is low; the sum memory does at most one
// read and one write each cycle, with the last write forwarded to the following read.
// A classify word passes the stage 1 and stage 2 registers into the output queue.
// After reset a clearing pass zeroes all MAX_PIXELS (524288) sum memory entries;
// in_stall stays high during it, cfg writes are taken as usual.
// in_stall also rises when the four-entry output queue could overflow.

module depth_background_subtractor_top
  import dbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  phase_t phase_r, phase_nxt;
  logic [PIX_AW-1:0] clr_addr_r;

  logic [FP_W-1:0]     frame_pixels_r;
  logic [MARGIN_W-1:0] margin_r;

  logic [PIX_AW-1:0] pos_r, pos_nxt;
  logic [FRM_W-1:0]  frames_r, frames_nxt;

  logic [SZ_W-1:0] eff_size;
  logic            in_acc;
  logic            is_last;
  logic            learn_en;

  logic               s1_valid_r;
  logic               s1_cls_r;
  logic               s1_we_r;
  logic               s1_last_r;
  logic [DEPTH_W-1:0] s1_depth_r;
  logic [PIX_AW-1:0]  s1_addr_r;
  logic [FRM_W-1:0]   s1_frames_r;

  logic              fwd_valid_r;
  logic [PIX_AW-1:0] fwd_addr_r;
  logic [SUM_W-1:0]  fwd_data_r;

  logic [SUM_W-1:0]  ram_rdata;
  logic [SUM_W-1:0]  rd_sum;
  logic [SUM_W-1:0]  new_sum;
  logic              s1_wr;
  logic              ram_we;
  logic [PIX_AW-1:0] ram_waddr;
  logic [SUM_W-1:0]  ram_wdata;

  logic              s2_valid_r;
  logic              s2_last_r;
  logic              s2_fzero_r;
  logic [SUM_W-1:0]  s2_sum_r;
  logic [PROD_W-1:0] s2_df_r;
  logic [PROD_W-1:0] s2_mf_r;
  logic [CMP_W-1:0]  hi_bound;
  logic [CMP_W-1:0]  lo_test;
  logic              fg;

  out_word_t        oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_r;
  logic [OQ_AW-1:0] oq_rd_r;
  logic [OQ_CW-1:0] oq_cnt_r, oq_cnt_nxt;
  logic [OQ_CW-1:0] oq_busy;
  logic             oq_push;
  logic             oq_pop;

  // phase control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CLEAR;
      clr_addr_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (phase_r == PH_CLEAR) begin
        clr_addr_r <= clr_addr_r + PIX_AW'(1);
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_CLEAR: begin
        if (clr_addr_r == PIX_AW'(MAX_PIXELS - 1)) begin
          phase_nxt = PH_RUN;
        end
      end
      PH_RUN:   phase_nxt = PH_RUN;
      default:  phase_nxt = PH_CLEAR;
    endcase
  end

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pixels_r <= FP_RESET;
      margin_r       <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_PIXELS: frame_pixels_r <= cfg_data[FP_W-1:0];
        CFG_MARGIN:       margin_r <= cfg_data[MARGIN_W-1:0];
        default:          ;
      endcase
    end
  end

  // stage 0: position, frame count, memory read
  always_comb begin
    if (frame_pixels_r == '0) begin
      eff_size = SZ_W'(1);
    end else if (SZ_W'(frame_pixels_r) > SZ_W'(MAX_PIXELS)) begin
      eff_size = SZ_W'(MAX_PIXELS);
    end else begin
      eff_size = SZ_W'(frame_pixels_r);
    end
  end

  assign oq_busy  = oq_cnt_r + OQ_CW'(s1_valid_r && s1_cls_r) + OQ_CW'(s2_valid_r);
  assign in_stall = (phase_r != PH_RUN) || (oq_busy >= OQ_CW'(OQ_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign is_last  = SZ_W'(pos_r) >= (eff_size - SZ_W'(1));
  assign learn_en = (in_word.req_type == REQ_LEARN) && (frames_r < FRM_W'(MAX_FRAMES));

  always_comb begin
    pos_nxt    = pos_r;
    frames_nxt = frames_r;
    if (in_acc) begin
      pos_nxt = is_last ? '0 : pos_r + PIX_AW'(1);
      if (learn_en && is_last) begin
        frames_nxt = frames_r + FRM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      frames_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      frames_r <= frames_nxt;
    end
  end

  // stage 1: read data, forward, write back, products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_acc;
      fwd_valid_r <= s1_wr;
    end
    s1_cls_r    <= in_word.req_type == REQ_CLASSIFY;
    s1_we_r     <= learn_en;
    s1_last_r   <= is_last;
    s1_depth_r  <= in_word.depth;
    s1_addr_r   <= pos_r;
    s1_frames_r <= frames_r;
    fwd_addr_r  <= s1_addr_r;
    fwd_data_r  <= new_sum;
  end

  assign rd_sum  = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : ram_rdata;
  assign new_sum = rd_sum + SUM_W'(s1_depth_r);
  assign s1_wr   = s1_valid_r && s1_we_r;

  assign ram_we    = (phase_r == PH_CLEAR) || s1_wr;
  assign ram_waddr = (phase_r == PH_CLEAR) ? clr_addr_r : s1_addr_r;
  assign ram_wdata = (phase_r == PH_CLEAR) ? '0 : new_sum;

  dbs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_PIXELS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // stage 2: compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && s1_cls_r;
    end
    s2_last_r  <= s1_last_r;
    s2_fzero_r <= s1_frames_r == '0;
    s2_sum_r   <= rd_sum;
    s2_df_r    <= PROD_W'(s1_depth_r) * PROD_W'(s1_frames_r);
    s2_mf_r    <= PROD_W'(margin_r) * PROD_W'(s1_frames_r);
  end

  assign hi_bound = CMP_W'(s2_sum_r) + CMP_W'(s2_mf_r);
  assign lo_test  = CMP_W'(s2_df_r) + CMP_W'(s2_mf_r);
  assign fg = !s2_fzero_r &&
              ((CMP_W'(s2_df_r) > hi_bound) || (lo_test < CMP_W'(s2_sum_r)));

  // output queue
  assign oq_push = s2_valid_r;
  assign oq_pop  = out_valid && !out_stall;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    case ({oq_push, oq_pop})
      2'b10:   oq_cnt_nxt = oq_cnt_r + OQ_CW'(1);
      2'b01:   oq_cnt_nxt = oq_cnt_r - OQ_CW'(1);
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQ_AW'(1);
      end
    end
    if (oq_push) begin
      oq_r[oq_wr_r] <= '{foreground: fg, last_of_frame: s2_last_r};
    end
  end

  assign out_valid = oq_cnt_r != '0;
  assign out_word  = oq_r[oq_rd_r];

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CLEAR |-> !s1_valid_r && !s2_valid_r && !in_acc)
    else $error("item in flight during clearing pass");

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_busy <= OQ_CW'(OQ_DEPTH))
    else $error("output queue overcommitted");

  a_frames_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    frames_r <= FRM_W'(MAX_FRAMES))
    else $error("frame count beyond limit");

  a_learn_writes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && learn_en |=> s1_wr && ram_we && ram_waddr == $past(pos_r))
    else $error("learn word not written back");

  a_pop_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r == '0 |=> oq_cnt_r <= OQ_CW'(1))
    else $error("queue grew by more than one");

endmodule

`default_nettype wire

/* rtl/dbs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
